>>> src/nfsd_pkg.sv
// Shared constants, types and a helper function for the server dispatcher.
package nfsd_pkg;

    localparam int SERVERS     = 16;
    localparam int COUNT_WIDTH = 20;
    localparam int MAX_RESULTS = 16;

    localparam int SRV_W  = (SERVERS > 1) ? $clog2(SERVERS) : 1;
    localparam int K_W    = $clog2(SERVERS + 1) + 1;
    localparam int RES_W  = $clog2(MAX_RESULTS + 1);
    localparam int CFG_W  = 5;
    localparam int ARR_W  = 31;
    localparam int TIME_W = 32;
    localparam int ID_W   = 4;
    localparam int MAXC_W = 20;

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    localparam logic CMD_DISPATCH = 1'b0;
    localparam logic CMD_REPORT   = 1'b1;

    typedef struct packed {
        logic cap_in;
        logic norm_step;
        logic disp_wr;
        logic max_step;
        logic eq_cap;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic is_report;
        logic idx_ge_k;
        logic scan_last;
        logic out_free;
        logic emit_last;
        logic eq_any;
    } t_sts;

    function automatic logic [SRV_W-1:0] lowest_set(input logic [SERVERS-1:0] v);
        logic [SRV_W-1:0] r;
        r = '0;
        for (int i = SERVERS - 1; i >= 0; i--) begin
            if (v[i]) begin
                r = SRV_W'(i);
            end
        end
        return r;
    endfunction

endpackage

>>> src/nfsd_if.sv
// Valid/ready channel interfaces for request and result beats.
interface nfsd_in_if;
    logic                          valid;
    logic                          ready;
    logic                          command;
    logic [nfsd_pkg::ARR_W-1:0]    arrival_time;
    logic [nfsd_pkg::ARR_W-1:0]    load_time;

    modport source (output valid, command, arrival_time, load_time, input ready);
    modport sink   (input valid, command, arrival_time, load_time, output ready);
endinterface

interface nfsd_out_if;
    logic                          valid;
    logic                          ready;
    logic [nfsd_pkg::ID_W-1:0]     server_id;
    logic                          dropped;
    logic [nfsd_pkg::MAXC_W-1:0]   max_count;
    logic                          last;

    modport source (output valid, server_id, dropped, max_count, last, input ready);
    modport sink   (input valid, server_id, dropped, max_count, last, output ready);
endinterface

>>> src/nfsd_ctrl.sv
// Sequencer for dispatch and busiest-server report.
module nfsd_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  nfsd_pkg::t_sts  i_sts,
    output nfsd_pkg::t_cmd  o_cmd
);
    import nfsd_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_DCMP  = 3'd1;
    localparam logic [2:0] ST_DWR   = 3'd2;
    localparam logic [2:0] ST_RMAX  = 3'd3;
    localparam logic [2:0] ST_REQ   = 3'd4;
    localparam logic [2:0] ST_REMIT = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       accept;

    assign o_in_ready = (r_state == ST_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    o_cmd.cap_in = 1'b1;
                    n_state      = ST_DCMP;
                end
            end
            ST_DCMP: begin
                // free vector is captured every cycle here
                if (i_sts.is_report) begin
                    n_state = ST_RMAX;
                end else if (i_sts.idx_ge_k) begin
                    o_cmd.norm_step = 1'b1;
                end else begin
                    n_state = ST_DWR;
                end
            end
            ST_DWR: begin
                if (i_sts.out_free) begin
                    o_cmd.disp_wr = 1'b1;
                    n_state       = ST_IDLE;
                end
            end
            ST_RMAX: begin
                o_cmd.max_step = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = ST_REQ;
                end
            end
            ST_REQ: begin
                o_cmd.eq_cap = 1'b1;
                n_state      = ST_REMIT;
            end
            ST_REMIT: begin
                if (!i_sts.eq_any) begin
                    n_state = ST_IDLE;
                end else if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_sts.emit_last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

>>> src/nfsd_dp.sv
// Server free times, served counts, selection logic and result register.
module nfsd_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [nfsd_pkg::CFG_W-1:0]    i_cfg_data,
    input  logic                          i_command,
    input  logic [nfsd_pkg::ARR_W-1:0]    i_arrival_time,
    input  logic [nfsd_pkg::ARR_W-1:0]    i_load_time,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic [nfsd_pkg::ID_W-1:0]     o_server_id,
    output logic                          o_dropped,
    output logic [nfsd_pkg::MAXC_W-1:0]   o_max_count,
    output logic                          o_last,
    input  nfsd_pkg::t_cmd                i_cmd,
    output nfsd_pkg::t_sts                o_sts
);
    import nfsd_pkg::*;

    logic [CFG_W-1:0]       r_num;
    logic [SRV_W-1:0]       r_idx;
    logic [TIME_W-1:0]      r_ft  [SERVERS];
    logic [COUNT_WIDTH-1:0] r_cnt [SERVERS];
    logic                   r_cmd;
    logic [ARR_W-1:0]       r_arr;
    logic [ARR_W-1:0]       r_load;
    logic [SERVERS-1:0]     r_free;
    logic [SRV_W-1:0]       r_scan;
    logic [COUNT_WIDTH-1:0] r_max;
    logic [SERVERS-1:0]     r_eq;
    logic [RES_W-1:0]       r_nres;
    logic                   r_ov;
    logic [ID_W-1:0]        r_oid;
    logic                   r_odrop;
    logic [MAXC_W-1:0]      r_omax;
    logic                   r_olast;

    logic [K_W-1:0]         k;
    logic [SERVERS-1:0]     in_use;
    logic [SERVERS-1:0]     ge_start;
    logic [SERVERS-1:0]     free_now;
    logic [SERVERS-1:0]     free_hi;
    logic [SRV_W-1:0]       pick;
    logic                   found;
    logic [SRV_W-1:0]       epick;
    logic [SERVERS-1:0]     eq_rest;
    logic                   emit_last;
    logic                   out_free;

    always_comb begin
        if (r_num == '0) begin
            k = K_W'(1);
        end else if (32'(r_num) > SERVERS) begin
            k = K_W'(SERVERS);
        end else begin
            k = K_W'(r_num);
        end
    end

    always_comb begin
        for (int s = 0; s < SERVERS; s++) begin
            in_use[s]   = K_W'(s) < k;
            ge_start[s] = SRV_W'(s) >= r_idx;
            free_now[s] = in_use[s] && (r_ft[s] <= {1'b0, r_arr});
        end
    end

    assign free_hi = r_free & ge_start;
    assign found   = |r_free;
    assign pick    = (|free_hi) ? lowest_set(free_hi) : lowest_set(r_free);

    assign epick = lowest_set(r_eq);
    always_comb begin
        for (int s = 0; s < SERVERS; s++) begin
            eq_rest[s] = r_eq[s] && (SRV_W'(s) != epick);
        end
    end
    assign emit_last = (eq_rest == '0) || (r_nres == RES_W'(MAX_RESULTS - 1));

    assign out_free = !r_ov || i_out_ready;

    assign o_sts.is_report = (r_cmd == CMD_REPORT);
    assign o_sts.idx_ge_k  = K_W'(r_idx) >= k;
    assign o_sts.scan_last = (K_W'(r_scan) + K_W'(1)) == k;
    assign o_sts.out_free  = out_free;
    assign o_sts.emit_last = emit_last;
    assign o_sts.eq_any    = |r_eq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num <= CFG_W'(SERVERS);
        end else if (i_cfg_we) begin
            r_num <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
            for (int s = 0; s < SERVERS; s++) begin
                r_ft[s]  <= '0;
                r_cnt[s] <= '0;
            end
        end else if (i_cmd.norm_step) begin
            r_idx <= SRV_W'(K_W'(r_idx) - k);
        end else if (i_cmd.disp_wr) begin
            r_idx <= ((K_W'(r_idx) + K_W'(1)) >= k) ? '0 : r_idx + SRV_W'(1);
            if (found) begin
                r_ft[pick] <= {1'b0, r_arr} + {1'b0, r_load};
                if (r_cnt[pick] != COUNT_MAX) begin
                    r_cnt[pick] <= r_cnt[pick] + COUNT_WIDTH'(1);
                end
            end
        end
    end

    // request capture and working registers
    always_ff @(posedge i_clk) begin
        r_free <= free_now;
        if (i_cmd.cap_in) begin
            r_cmd  <= i_command;
            r_arr  <= i_arrival_time;
            r_load <= i_load_time;
            r_scan <= '0;
            r_max  <= '0;
        end else if (i_cmd.max_step) begin
            r_scan <= r_scan + SRV_W'(1);
            if (r_cnt[r_scan] > r_max) begin
                r_max <= r_cnt[r_scan];
            end
        end
        if (i_cmd.eq_cap) begin
            r_nres <= '0;
            for (int s = 0; s < SERVERS; s++) begin
                r_eq[s] <= in_use[s] && (r_cnt[s] == r_max);
            end
        end else if (i_cmd.emit) begin
            r_nres <= r_nres + RES_W'(1);
            r_eq   <= emit_last ? '0 : eq_rest;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_cmd.disp_wr || i_cmd.emit) begin
            r_ov <= 1'b1;
        end else if (i_out_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.disp_wr) begin
            r_oid   <= found ? ID_W'(pick) : '0;
            r_odrop <= !found;
            r_omax  <= '0;
            r_olast <= 1'b1;
        end else if (i_cmd.emit) begin
            r_oid   <= ID_W'(epick);
            r_odrop <= 1'b0;
            r_omax  <= MAXC_W'(r_max);
            r_olast <= emit_last;
        end
    end

    assign o_out_valid = r_ov;
    assign o_server_id = r_oid;
    assign o_dropped   = r_odrop;
    assign o_max_count = r_omax;
    assign o_last      = r_olast;

endmodule

>>> src/next_free_server_dispatcher_unit.sv
// Dispatch: accept, compare, then select/write, which waits while the output beat is not taken;
// extra compare steps bring the request index back below a lowered server count.
// Report: accept, scan the N in-use counts for the maximum, a match step, then one
// result beat per cycle while the output is taken.
// Synchronous active-low reset: all servers free, counts and request index zero,
// server count set to SERVERS. One input beat is worked on at a time.
module next_free_server_dispatcher_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [nfsd_pkg::CFG_W-1:0]  i_cfg_data,
    nfsd_in_if.sink                     i_in,
    nfsd_out_if.source                  o_out
);
    import nfsd_pkg::*;

    t_cmd cmd;
    t_sts sts;
    logic in_ready;

    assign i_in.ready = in_ready;

    nfsd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    nfsd_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_command      (i_in.command),
        .i_arrival_time (i_in.arrival_time),
        .i_load_time    (i_in.load_time),
        .i_out_ready    (o_out.ready),
        .o_out_valid    (o_out.valid),
        .o_server_id    (o_out.server_id),
        .o_dropped      (o_out.dropped),
        .o_max_count    (o_out.max_count),
        .o_last         (o_out.last),
        .i_cmd          (cmd),
        .o_sts          (sts)
    );

endmodule

>>> src/nfsd_chk.sv
// Port-level checks for the server dispatcher, bound to the top level.
module nfsd_chk (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        i_in_ready,
    input  logic                        i_out_valid,
    input  logic                        i_out_ready,
    input  logic [nfsd_pkg::ID_W-1:0]   i_server_id,
    input  logic                        i_dropped,
    input  logic [nfsd_pkg::MAXC_W-1:0] i_max_count,
    input  logic                        i_last
);

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("input accepted while previous beat in progress");

    a_drop_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_dropped) |-> (i_last && i_server_id == '0 && i_max_count == '0))
        else $error("dropped beat with bad fields");

    a_report_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_last) |-> !i_dropped)
        else $error("non-final beat marked dropped");

    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_server_id)
            && $stable(i_last) && $stable(i_max_count)))
        else $error("stalled result beat changed");

endmodule

bind next_free_server_dispatcher_unit nfsd_chk u_nfsd_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_server_id (o_out.server_id),
    .i_dropped   (o_out.dropped),
    .i_max_count (o_out.max_count),
    .i_last      (o_out.last)
);

>>> test/nfsd_dispatch_checker.sv
// Checker for the server dispatcher: tracks server state, predicts each result beat and compares.
`timescale 1ns / 100ps

module nfsd_dispatch_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [nfsd_pkg::CFG_W-1:0]   i_cfg_data,
    nfsd_in_if                           i_req,
    nfsd_out_if                          i_res,
    output int                           o_fail_count,
    output int                           o_pending
);
    import nfsd_pkg::*;

    typedef struct packed {
        logic [ID_W-1:0]   server_id;
        logic              dropped;
        logic [MAXC_W-1:0] max_count;
        logic              last;
    } t_result;

    logic [TIME_W-1:0]      free_at [SERVERS];
    logic [COUNT_WIDTH-1:0] served  [SERVERS];
    int                     next_start;
    logic [CFG_W-1:0]       servers_cfg;
    t_result                beats_due [$];
    int                     fail_total;

    function automatic int servers_in_use();
        if (servers_cfg == 0) return 1;
        if (servers_cfg > SERVERS) return SERVERS;
        return int'(servers_cfg);
    endfunction

    function automatic void enqueue_due(input t_result r);
        beats_due.insert(beats_due.size(), r);
    endfunction

    task automatic predict_beat(input logic cmd, input logic [ARR_W-1:0] arr,
                                input logic [ARR_W-1:0] load);
        int                     k;
        int                     start;
        int                     cand;
        int                     hits;
        int                     n;
        bit                     found;
        logic [COUNT_WIDTH-1:0] top_count;
        t_result                r;
        k = servers_in_use();
        if (cmd == CMD_DISPATCH) begin
            start = next_start % k;
            found = 1'b0;
            r     = '0;
            r.last = 1'b1;
            for (int step = 0; step < k; step++) begin
                cand = (start + step) % k;
                if (!found && free_at[cand] <= {1'b0, arr}) begin
                    found       = 1'b1;
                    r.server_id = ID_W'(cand);
                end
            end
            next_start = (start + 1 >= k) ? 0 : start + 1;
            if (!found) begin
                r.dropped = 1'b1;
            end else begin
                free_at[r.server_id] = {1'b0, arr} + {1'b0, load};
                if (served[r.server_id] != COUNT_MAX) begin
                    served[r.server_id] = served[r.server_id] + COUNT_WIDTH'(1);
                end
            end
            enqueue_due(r);
        end else begin
            top_count = '0;
            for (int s = 0; s < k; s++) begin
                if (served[s] > top_count) top_count = served[s];
            end
            hits = 0;
            for (int s = 0; s < k; s++) begin
                if (served[s] == top_count) hits++;
            end
            if (hits > MAX_RESULTS) hits = MAX_RESULTS;
            n = 0;
            for (int s = 0; s < k; s++) begin
                if (served[s] == top_count && n < hits) begin
                    r.server_id = ID_W'(s);
                    r.dropped   = 1'b0;
                    r.max_count = MAXC_W'(top_count);
                    r.last      = (n == hits - 1);
                    enqueue_due(r);
                    n++;
                end
            end
        end
    endtask

    task automatic check_beat();
        t_result want;
        t_result got;
        got.server_id = i_res.server_id;
        got.dropped   = i_res.dropped;
        got.max_count = i_res.max_count;
        got.last      = i_res.last;
        if (beats_due.size() == 0) begin
            fail_total++;
            if (fail_total <= 10) begin
                $display("unexpected result beat: id %0d dropped %0d max %0d last %0d",
                         got.server_id, got.dropped, got.max_count, got.last);
            end
        end else begin
            want = beats_due.pop_front();
            if (got.server_id !== want.server_id || got.dropped !== want.dropped ||
                got.max_count !== want.max_count || got.last !== want.last) begin
                fail_total++;
                if (fail_total <= 10) begin
                    $display("result mismatch: expected id %0d dropped %0d max %0d last %0d,",
                             want.server_id, want.dropped, want.max_count, want.last);
                    $display("                 got      id %0d dropped %0d max %0d last %0d",
                             got.server_id, got.dropped, got.max_count, got.last);
                end
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < SERVERS; s++) begin
                free_at[s] = '0;
                served[s]  = '0;
            end
            next_start  = 0;
            servers_cfg = CFG_W'(SERVERS);
            beats_due.delete();
        end else begin
            if (i_cfg_we) servers_cfg = i_cfg_data;
            if (i_res.valid && i_res.ready) check_beat();
            if (i_req.valid && i_req.ready) begin
                predict_beat(i_req.command, i_req.arrival_time, i_req.load_time);
            end
        end
        o_pending    = beats_due.size();
        o_fail_count = fail_total;
    end

endmodule

>>> test/next_free_server_dispatcher_unit_tb.sv
// Testbench top for the server dispatcher: clock, reset, stimulus, stalls and verdict.
`timescale 1ns / 100ps

module next_free_server_dispatcher_unit_tb;
    import nfsd_pkg::*;

    localparam int          PHASES          = 10;
    localparam int          ITEMS_PER_PHASE = 43;
    localparam int          HOLD_CYCLES     = 300;
    localparam int          QUIET_LIMIT     = 5000;
    localparam int          SETTLE_CYCLES   = 4;
    localparam int          END_CYCLES      = 40;
    localparam int unsigned MAX_ARRIVAL     = 32'h7FFF_FFFF;
    localparam logic [CFG_W-1:0] SERVER_PLAN [PHASES] =
        '{5'd4, 5'd31, 5'd2, 5'd17, 5'd9, 5'd1, 5'd16, 5'd0, 5'd13, 5'd16};

    logic             i_clk;
    logic             i_rst_n;
    logic             cfg_we;
    logic [CFG_W-1:0] cfg_data;
    logic             rx_ready = 1'b0;
    logic             hold_go;
    logic             hold_done;
    int               hold_left;
    int               send_idle_pct;
    int               recv_stall_pct;
    int               quiet_cycles;
    int               fail_count;
    int               pending;

    nfsd_in_if  req_ch ();
    nfsd_out_if res_ch ();

    assign res_ch.ready = rx_ready;

    next_free_server_dispatcher_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data),
        .i_in       (req_ch),
        .o_out      (res_ch)
    );

    nfsd_dispatch_checker dispatch_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_data   (cfg_data),
        .i_req        (req_ch),
        .i_res        (res_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    // receiver: random stalls, plus one long hold-off to back the block up
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rx_ready  <= 1'b0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (hold_go && !hold_done) begin
            rx_ready  <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if (hold_left != 0) begin
            rx_ready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else begin
            rx_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            quiet_cycles <= 0;
        end else if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("next_free_server_dispatcher_unit_tb: FAIL");
            $finish;
        end
    end

    task automatic send_beat(input logic cmd, input logic [ARR_W-1:0] arr,
                             input logic [ARR_W-1:0] load);
        while ($urandom_range(99) < send_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.command      <= cmd;
        req_ch.arrival_time <= arr;
        req_ch.load_time    <= load;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
    endtask

    task automatic drain(input int extra);
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (extra) @(posedge i_clk);
    endtask

    task automatic write_servers(input logic [CFG_W-1:0] count);
        drain(SETTLE_CYCLES);
        cfg_we   <= 1'b1;
        cfg_data <= count;
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    initial begin
        int unsigned     base_time;
        int unsigned     step;
        int              pick;
        int              items_sent;
        logic            cmd;
        logic [ARR_W-1:0] arr;
        logic [ARR_W-1:0] load;

        i_rst_n             <= 1'b0;
        cfg_we              <= 1'b0;
        cfg_data            <= '0;
        hold_go             <= 1'b0;
        req_ch.valid        <= 1'b0;
        req_ch.command      <= CMD_DISPATCH;
        req_ch.arrival_time <= '0;
        req_ch.load_time    <= '0;
        send_idle_pct        = 17;
        recv_stall_pct      <= 79;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset count of 16
        send_beat(CMD_REPORT, '0, '0);
        send_beat(CMD_DISPATCH, 31'd0, 31'd0);
        send_beat(CMD_DISPATCH, 31'd0, 31'h7FFF_FFFF);
        send_beat(CMD_DISPATCH, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
        send_beat(CMD_DISPATCH, 31'd3, 31'd5);
        send_beat(CMD_REPORT, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
        // single server, lowered below the request index; busy, drop, exact free time
        write_servers(5'd1);
        send_beat(CMD_DISPATCH, 31'd10, 31'd100);
        send_beat(CMD_DISPATCH, 31'd20, 31'd5);
        send_beat(CMD_DISPATCH, 31'd110, 31'd1);
        send_beat(CMD_REPORT, '0, '0);
        // zero count acts as one
        write_servers(5'd0);
        send_beat(CMD_DISPATCH, 31'd111, 31'd0);
        send_beat(CMD_DISPATCH, 31'd111, 31'd9);
        send_beat(CMD_REPORT, '0, '0);
        // count above range acts as full bank
        write_servers(5'd31);
        send_beat(CMD_REPORT, '0, '0);

        base_time  = 200;
        items_sent = 0;
        for (int ph = 0; ph < PHASES; ph++) begin
            write_servers(SERVER_PLAN[ph]);
            for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
                if (items_sent < 143) begin
                    send_idle_pct   = 17;
                    recv_stall_pct <= 79;
                end else if (items_sent < 286) begin
                    send_idle_pct   = 79;
                    recv_stall_pct <= 17;
                end else begin
                    send_idle_pct   = 0;
                    recv_stall_pct <= 0;
                end
                if (items_sent == 330) hold_go <= 1'b1;
                pick = $urandom_range(99);
                if (pick < 15) begin
                    cmd  = CMD_REPORT;
                    arr  = ARR_W'($urandom);
                    load = ARR_W'($urandom);
                end else if (pick < 20) begin
                    // out-of-order arrival anywhere in the range
                    cmd  = CMD_DISPATCH;
                    arr  = ARR_W'($urandom);
                    load = ARR_W'($urandom_range(0, 60_000_000));
                end else begin
                    step      = $urandom_range(0, 9_000_000);
                    base_time = (base_time > MAX_ARRIVAL - step) ? MAX_ARRIVAL
                                                                 : base_time + step;
                    cmd  = CMD_DISPATCH;
                    arr  = base_time[ARR_W-1:0];
                    load = ARR_W'($urandom_range(0, 60_000_000));
                end
                send_beat(cmd, arr, load);
                items_sent++;
            end
        end

        drain(END_CYCLES);
        if (fail_count == 0) begin
            $display("next_free_server_dispatcher_unit_tb: PASS");
        end else begin
            $display("next_free_server_dispatcher_unit_tb: FAIL");
        end
        $finish;
    end

endmodule
